@@ rtl/core/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler package
// Shared widths, defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int unsigned CapacityDef = 32;
  localparam int unsigned IndexW      = 32;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CountW      = 6;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFetch,
    StStatus
  } state_e;

endpackage

@@ rtl/core/bsr_in_if.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler input channel
// Valid/ready channel carrying one segment byte or one consumer read word.
// ----------------------------------------------------------------------------
interface bsr_in_if;
  import bsr_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [IndexW-1:0] stream_index;
  logic [ByteW-1:0]  data_byte;
  logic              has_data;
  logic              segment_end;
  logic              eof;
  logic [CountW-1:0] read_count;

  modport source (
    output valid, action, stream_index, data_byte, has_data, segment_end, eof,
           read_count,
    input  ready
  );

  modport sink (
    input  valid, action, stream_index, data_byte, has_data, segment_end, eof,
           read_count,
    output ready
  );

endinterface

@@ rtl/core/bsr_out_if.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler output channel
// Valid/ready channel carrying one released byte or one status word.
// ----------------------------------------------------------------------------
interface bsr_out_if;
  import bsr_pkg::*;

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  out_byte;
  logic              byte_valid;
  logic              last;
  logic              stream_ended;
  logic [CountW-1:0] pending_count;
  logic [IndexW-1:0] expected_index;

  modport source (
    output valid, out_byte, byte_valid, last, stream_ended, pending_count,
           expected_index,
    input  ready
  );

  modport sink (
    input  valid, out_byte, byte_valid, last, stream_ended, pending_count,
           expected_index,
    output ready
  );

endinterface

@@ rtl/core/bsr_ram.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/byte_stream_reassembler.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler
// Stores out-of-order stream bytes in a ring and releases the in-order run.
// ----------------------------------------------------------------------------
// Each input word is one segment byte at an absolute stream position, or a
// consumer read that frees output space. Bytes inside the window
// [expected, expected + CAPACITY - output fill) are written into a ring RAM
// and marked valid; all others are dropped. A segment byte is stored in the
// cycle it is accepted; after it, the sequencer walks the ring from the head
// slot and releases each contiguous byte as one output word, read from the
// RAM in StScan and registered in StFetch, then closes with one status word
// (last set). Read words and words after the end of stream take one cycle
// and give only the status word. Output back-pressure can stall the walk and
// the status word. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module byte_stream_reassembler
  import bsr_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsr_in_if.sink    in_i,
  bsr_out_if.source out_o
);

  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned SumW  = SlotW + 1;

  state_e state_q, state_d;

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [SlotW-1:0]    head_q, head_d;
  logic [IndexW-1:0]   next_q, next_d;
  logic [CountW-1:0]   fill_q, fill_d;
  logic [CountW-1:0]   pend_q, pend_d;
  logic                end_known_q, end_known_d;
  logic [IndexW:0]     end_pos_q, end_pos_d;
  logic                ended_q, ended_d;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q, out_byte_d;
  logic              byte_valid_q, byte_valid_d;
  logic              last_q, last_d;
  logic              fin_q, fin_d;
  logic [CountW-1:0] out_pend_q, out_pend_d;
  logic [IndexW-1:0] out_exp_q, out_exp_d;

  logic              out_free;
  logic              in_acc;
  logic              quick_item;
  logic [IndexW-1:0] offset;
  logic              in_window;
  logic [SumW-1:0]   slot_sum;
  logic [SlotW-1:0]  wr_slot;
  logic [SlotW-1:0]  head_next;
  logic              can_release;
  logic              ram_we;
  logic              ram_re;
  logic [ByteW-1:0]  ram_rdata;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign quick_item = ended_q || in_i.action;

  assign offset    = in_i.stream_index - next_q;
  assign in_window = (in_i.stream_index >= next_q) &&
                     (offset < (IndexW'(CAPACITY) - IndexW'(fill_q)));
  assign slot_sum  = SumW'(head_q) + SumW'(offset[SlotW-1:0]);
  assign wr_slot   = (slot_sum >= SumW'(CAPACITY)) ?
                     SlotW'(slot_sum - SumW'(CAPACITY)) : SlotW'(slot_sum);
  assign head_next = (head_q == SlotW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

  assign can_release = (fill_q < CountW'(CAPACITY)) && valid_q[head_q];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && !quick_item) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (!can_release) begin
          state_d = StStatus;
        end else if (out_free) begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = StScan;
      end
      StStatus: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Handshake and RAM control.
  always_comb begin
    in_i.ready = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_i.ready = out_free;
        ram_we     = in_acc && !quick_item && in_i.has_data && in_window;
      end
      StScan: begin
        ram_re = can_release && out_free;
      end
      StFetch, StStatus: begin
        ram_re = 1'b0;
      end
      default: ram_re = 1'b0;
    endcase
  end

  // Reassembly state and output register.
  always_comb begin
    valid_d      = valid_q;
    head_d       = head_q;
    next_d       = next_q;
    fill_d       = fill_q;
    pend_d       = pend_q;
    end_known_d  = end_known_q;
    end_pos_d    = end_pos_q;
    ended_d      = ended_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    last_d       = last_q;
    fin_d        = fin_q;
    out_pend_d   = out_pend_q;
    out_exp_d    = out_exp_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (quick_item) begin
            if (!ended_q) begin
              fill_d = (in_i.read_count >= fill_q) ? '0 : fill_q - in_i.read_count;
            end
            out_valid_d  = 1'b1;
            out_byte_d   = '0;
            byte_valid_d = 1'b0;
            last_d       = 1'b1;
            fin_d        = ended_q;
            out_pend_d   = pend_q;
            out_exp_d    = next_q;
          end else begin
            if (ram_we && !valid_q[wr_slot]) begin
              valid_d[wr_slot] = 1'b1;
              pend_d           = pend_q + 1'b1;
            end
            if (in_i.segment_end && in_i.eof) begin
              end_known_d = 1'b1;
              end_pos_d   = {1'b0, in_i.stream_index} + (IndexW + 1)'(in_i.has_data);
            end
          end
        end
      end
      StScan: begin
        if (can_release) begin
          if (out_free) begin
            valid_d[head_q] = 1'b0;
            head_d          = head_next;
            next_d          = next_q + 1'b1;
            fill_d          = fill_q + 1'b1;
            pend_d          = pend_q - 1'b1;
          end
        end else if (end_known_q && (end_pos_q <= {1'b0, next_q})) begin
          ended_d = 1'b1;
        end
      end
      StFetch: begin
        out_valid_d  = 1'b1;
        out_byte_d   = ram_rdata;
        byte_valid_d = 1'b1;
        last_d       = 1'b0;
        fin_d        = 1'b0;
        out_pend_d   = pend_q;
        out_exp_d    = next_q;
      end
      StStatus: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = '0;
          byte_valid_d = 1'b0;
          last_d       = 1'b1;
          fin_d        = ended_q;
          out_pend_d   = pend_q;
          out_exp_d    = next_q;
        end
      end
      default: out_valid_d = out_valid_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      head_q      <= '0;
      next_q      <= '0;
      fill_q      <= '0;
      pend_q      <= '0;
      end_known_q <= 1'b0;
      end_pos_q   <= '0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      head_q      <= head_d;
      next_q      <= next_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      end_known_q <= end_known_d;
      end_pos_q   <= end_pos_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    last_q       <= last_d;
    fin_q        <= fin_d;
    out_pend_q   <= out_pend_d;
    out_exp_q    <= out_exp_d;
  end

  bsr_ram #(
    .Width(ByteW),
    .Depth(CAPACITY)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_slot),
    .wdata_i(in_i.data_byte),
    .re_i   (ram_re),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.byte_valid     = byte_valid_q;
  assign out_o.last           = last_q;
  assign out_o.stream_ended   = fin_q;
  assign out_o.pending_count  = out_pend_q;
  assign out_o.expected_index = out_exp_q;

endmodule
